@@ rtl/core/euks_pkg.sv @@
// Shared types and constants of the Korean to Japanese double-byte code remapper.
package euks_pkg;

    localparam int C_VW = 15;
    localparam int C_QW = 7;
    localparam int C_QDEPTH_DEF = 4;

    localparam logic [7:0] C_HI_BASE  = 8'hA0;
    localparam logic [7:0] C_LEAD_MIN = 8'h81;
    localparam logic [7:0] C_LEAD_MAX = 8'hFE;

    localparam logic [7:0] C_EX0_HI = 8'hBE;
    localparam logic [7:0] C_EX0_LO = 8'hC6;
    localparam logic [7:0] C_EX1_HI = 8'hB7;
    localparam logic [7:0] C_EX1_LO = 8'hB8;
    localparam logic [7:0] C_EX2_HI = 8'hB8;
    localparam logic [7:0] C_EX2_LO = 8'hD5;
    localparam logic [7:0] C_SUB_HI  = 8'hA8;
    localparam logic [7:0] C_SUB0_LO = 8'hA1;
    localparam logic [7:0] C_SUB1_LO = 8'hA2;
    localparam logic [7:0] C_SUB2_LO = 8'hA3;

    localparam int C_ROW  = 160;
    localparam int C_BIAS = 95;

    localparam int C_GAP1_AT = 3074;
    localparam int C_GAP1    = 44;
    localparam int C_GAP2_AT = 4535;
    localparam int C_GAP2    = 12096;
    localparam int C_GAP3_AT = 18622;
    localparam int C_GAP3    = 466;
    localparam int C_VMAX    = 19450;

    // gap thresholds folded back onto the unshifted code
    localparam int C_RAW_T1  = C_GAP1_AT;
    localparam int C_RAW_T2  = C_GAP2_AT - C_GAP1;
    localparam int C_RAW_T3  = C_GAP3_AT - C_GAP1 - C_GAP2;
    localparam int C_RAW_MAX = C_VMAX - C_GAP1 - C_GAP2 - C_GAP3;

    localparam int C_DIV      = 189;
    localparam int C_RECIP_SH = 22;
    localparam int C_RECIP    = ((1 << C_RECIP_SH) + C_DIV - 1) / C_DIV;
    localparam int C_PW       = C_VW + 15;

    localparam logic [7:0] C_JH_BASE = 8'h88;
    localparam logic [7:0] C_JL_BASE = 8'h40;

    typedef logic [C_VW-1:0] t_val;

    typedef struct packed {
        logic is_pair;
        t_val val;
        logic end_mark;
    } t_cls_item;

endpackage

@@ rtl/core/euks_if.sv @@
// Request channel interfaces for the input bytes and the converted bytes.
interface euks_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       text_end;

    modport source (output valid, output in_byte, output text_end, input ready);
    modport sink (input valid, input in_byte, input text_end, output ready);
endinterface

interface euks_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       end_mark;

    modport source (output valid, output out_byte, output run_last, output end_mark,
                    input ready);
    modport sink (input valid, input out_byte, input run_last, input end_mark,
                  output ready);
endinterface

@@ rtl/core/euks_front.sv @@
// Front end: lead byte tracking, pair classification and linear code computation.
module euks_front import euks_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    euks_in_if.sink   i_in,
    input  logic      i_q_ready,
    output logic      o_wr_valid,
    output t_cls_item o_wr_item
);

    logic       r_pending, n_pending;
    logic [7:0] r_held, n_held;
    logic       w_acc;
    logic       w_is_lead;
    logic       w_pair_ok;
    logic [7:0] w_b;
    logic [7:0] w_hi, w_lo;
    logic [7:0] w_hi_d, w_lo_d;
    t_val       w_raw;

    assign i_in.ready = i_q_ready;

    always_comb begin
        w_b       = i_in.in_byte;
        w_acc     = i_in.valid && i_q_ready;
        w_is_lead = (w_b >= C_LEAD_MIN) && (w_b <= C_LEAD_MAX);
        w_pair_ok = (r_held >= C_HI_BASE) && (w_b >= C_HI_BASE);

        w_hi = r_held;
        w_lo = w_b;
        if (r_held == C_EX0_HI && w_b == C_EX0_LO) begin
            w_hi = C_SUB_HI;
            w_lo = C_SUB0_LO;
        end else if (r_held == C_EX1_HI && w_b == C_EX1_LO) begin
            w_hi = C_SUB_HI;
            w_lo = C_SUB1_LO;
        end else if (r_held == C_EX2_HI && w_b == C_EX2_LO) begin
            w_hi = C_SUB_HI;
            w_lo = C_SUB2_LO;
        end

        w_hi_d = w_hi - C_HI_BASE;
        w_lo_d = w_lo - C_HI_BASE;
        w_raw  = t_val'(w_hi_d[6:0]) * t_val'(C_ROW) + t_val'(w_lo_d[6:0]) + t_val'(C_BIAS);

        o_wr_valid         = w_acc && (r_pending ? w_pair_ok : !w_is_lead);
        o_wr_item.is_pair  = r_pending;
        o_wr_item.val      = r_pending ? w_raw : t_val'(w_b);
        o_wr_item.end_mark = i_in.text_end;

        n_pending = r_pending;
        n_held    = r_held;
        if (w_acc) begin
            if (r_pending) begin
                n_pending = 1'b0;
            end else if (w_is_lead && !i_in.text_end) begin
                n_pending = 1'b1;
                n_held    = w_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
        end else begin
            r_pending <= n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

    a_held_is_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> (r_held >= C_LEAD_MIN && r_held <= C_LEAD_MAX))
        else $error("held byte is not a lead byte");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in.text_end) |=> !r_pending)
        else $error("lead byte held across text end");

    a_pair_consumes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_pending) |=> !r_pending)
        else $error("trail byte did not complete the pair");

endmodule

@@ rtl/core/euks_queue.sv @@
// Short request queue between the front end and the back end.
module euks_queue import euks_pkg::*; #(
    parameter int P_DEPTH = C_QDEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_wr_valid,
    input  t_cls_item i_wr_item,
    output logic      o_wr_ready,
    output logic      o_rd_valid,
    output t_cls_item o_rd_item,
    input  logic      i_rd_ready
);

    localparam int PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    t_cls_item         r_mem [P_DEPTH];
    logic [PW-1:0]     r_wp, n_wp;
    logic [PW-1:0]     r_rp, n_rp;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              w_push, w_pop;

    always_comb begin
        o_wr_ready = (r_cnt != CW'(P_DEPTH));
        o_rd_valid = (r_cnt != '0);
        o_rd_item  = r_mem[r_rp];
        w_push     = i_wr_valid && o_wr_ready;
        w_pop      = o_rd_valid && i_rd_ready;

        n_wp = r_wp;
        if (w_push) begin
            n_wp = (r_wp == PW'(P_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        n_rp = r_rp;
        if (w_pop) begin
            n_rp = (r_rp == PW'(P_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        n_cnt = r_cnt + CW'(w_push) - CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_wr_item;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(P_DEPTH))
        else $error("queue count beyond depth");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_valid |-> o_wr_ready)
        else $error("front end pushed into a full queue");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count lost a push");

endmodule

@@ rtl/core/euks_back.sv @@
// Back end: gap shift and range drop, divide by 189, and byte serialization.
module euks_back import euks_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rd_valid,
    input  t_cls_item  i_rd_item,
    output logic       o_rd_ready,
    euks_out_if.source o_out
);

    // gap stage
    logic            r_g_valid;
    t_cls_item       r_g;
    // divide stage
    logic            r_d_valid;
    logic [C_QW-1:0] r_d_q;
    t_cls_item       r_d;
    // output register
    logic            r_o_valid;
    logic            r_o_more;
    logic [7:0]      r_o_byte;
    logic [7:0]      r_o_lo;
    logic            r_o_end;

    logic            w_g_take, w_d_take, w_o_take;
    logic            w_keep;
    t_val            w_gap;
    t_val            w_rem;
    logic [C_PW-1:0] w_prod;

    always_comb begin
        w_o_take   = !r_o_valid || (o_out.ready && !r_o_more);
        w_d_take   = !r_d_valid || w_o_take;
        w_g_take   = !r_g_valid || w_d_take;
        o_rd_ready = w_g_take;

        if (i_rd_item.val > t_val'(C_RAW_T3)) begin
            w_gap = t_val'(C_GAP1 + C_GAP2 + C_GAP3);
        end else if (i_rd_item.val > t_val'(C_RAW_T2)) begin
            w_gap = t_val'(C_GAP1 + C_GAP2);
        end else if (i_rd_item.val > t_val'(C_RAW_T1)) begin
            w_gap = t_val'(C_GAP1);
        end else begin
            w_gap = '0;
        end
        w_keep = !i_rd_item.is_pair || (i_rd_item.val <= t_val'(C_RAW_MAX));

        w_prod = C_PW'(r_g.val) * C_PW'(C_RECIP);
        w_rem  = r_d.val - t_val'(r_d_q) * t_val'(C_DIV);

        o_out.valid    = r_o_valid;
        o_out.out_byte = r_o_byte;
        o_out.run_last = !r_o_more;
        o_out.end_mark = r_o_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_o_more  <= 1'b0;
        end else begin
            if (w_g_take) begin
                r_g_valid <= i_rd_valid && w_keep;
            end
            if (w_d_take) begin
                r_d_valid <= r_g_valid;
            end
            if (w_o_take) begin
                r_o_valid <= r_d_valid;
                r_o_more  <= r_d_valid && r_d.is_pair;
            end else if (o_out.ready && r_o_more) begin
                r_o_more <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_g_take) begin
            r_g.is_pair  <= i_rd_item.is_pair;
            r_g.end_mark <= i_rd_item.end_mark;
            r_g.val      <= i_rd_item.is_pair ? i_rd_item.val + w_gap : i_rd_item.val;
        end
        if (w_d_take) begin
            r_d   <= r_g;
            r_d_q <= w_prod[C_RECIP_SH +: C_QW];
        end
        if (w_o_take) begin
            r_o_end  <= r_d.end_mark;
            r_o_byte <= r_d.is_pair ? 8'(r_d_q) + C_JH_BASE : r_d.val[7:0];
            r_o_lo   <= w_rem[7:0] + C_JL_BASE;
        end else if (o_out.ready && r_o_more) begin
            r_o_byte <= r_o_lo;
        end
    end

    a_more_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_more |-> r_o_valid)
        else $error("second byte pending without a request");

    a_low_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_more && o_out.ready) |=> (r_o_valid && !r_o_more))
        else $error("low byte did not follow high byte");

    a_pair_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_g_valid && r_g.is_pair) |-> (r_g.val <= t_val'(C_VMAX)))
        else $error("out of range pair passed the gap stage");

endmodule

@@ rtl/core/euckr_to_sjis_code_remap.sv @@
// Top level of the Korean double-byte to Japanese double-byte code remapper.
//
// Input channel i_in carries one text byte per request with text_end on the
// last byte of a text. Output channel o_out carries converted bytes: a single
// byte passes through as one request, a mapped pair gives two requests (high
// byte, then low byte, run_last on the second). Unmapped pairs and a lead
// byte that arrives with text_end give no request.
// The request that completes an output byte passes through the queue, the
// gap stage, the divide stage and the output register, in that order.
// Throughput: one input byte per cycle while the queue has room; the output
// register sends one byte per cycle while o_out.ready is high, so a single
// byte or a whole pair keeps pace with its inputs. i_in.ready drops only when
// the P_QDEPTH entry queue is full, which happens only while the receiver
// holds o_out.ready low; the back end then holds its stages and the front end
// keeps filling the queue. Reset (synchronous, i_rst_n low) drops any held
// lead byte and empties the queue and all stages.
module euckr_to_sjis_code_remap import euks_pkg::*; #(
    parameter int P_QDEPTH = C_QDEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    euks_in_if.sink    i_in,
    euks_out_if.source o_out
);

    logic      w_wr_valid;
    logic      w_wr_ready;
    t_cls_item w_wr_item;
    logic      w_rd_valid;
    logic      w_rd_ready;
    t_cls_item w_rd_item;

    euks_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_ready  (w_wr_ready),
        .o_wr_valid (w_wr_valid),
        .o_wr_item  (w_wr_item)
    );

    euks_queue #(
        .P_DEPTH (P_QDEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_wr_valid),
        .i_wr_item  (w_wr_item),
        .o_wr_ready (w_wr_ready),
        .o_rd_valid (w_rd_valid),
        .o_rd_item  (w_rd_item),
        .i_rd_ready (w_rd_ready)
    );

    euks_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_valid (w_rd_valid),
        .i_rd_item  (w_rd_item),
        .o_rd_ready (w_rd_ready),
        .o_out      (o_out)
    );

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the Korean to Japanese double-byte code remapper.
import euks_pkg::*;

class remap_scoreboard;
    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       endm;
    } t_code_out;

    t_code_out  code_q[$];
    bit         lead_held;
    logic [7:0] lead_byte;
    int         n_errors;
    int         n_in;
    int         n_out;
    int         n_mapped;
    int         n_dropped;
    int         n_single;
    int         n_lone;

    function automatic bit map_pair(input logic [7:0] hi, input logic [7:0] lo,
                                    output logic [7:0] jh, output logic [7:0] jl);
        int unsigned v;
        int unsigned word;
        logic [7:0]  h;
        logic [7:0]  l;
        jh = '0;
        jl = '0;
        if (hi < C_HI_BASE || lo < C_HI_BASE) return 1'b0;
        h = hi;
        l = lo;
        if (h == C_EX0_HI && l == C_EX0_LO) begin
            h = C_SUB_HI;
            l = C_SUB0_LO;
        end else if (h == C_EX1_HI && l == C_EX1_LO) begin
            h = C_SUB_HI;
            l = C_SUB1_LO;
        end else if (h == C_EX2_HI && l == C_EX2_LO) begin
            h = C_SUB_HI;
            l = C_SUB2_LO;
        end
        v = (int'(h) - int'(C_HI_BASE)) * C_ROW + (int'(l) - int'(C_HI_BASE)) + C_BIAS;
        if (v > C_GAP1_AT) v += C_GAP1;
        if (v > C_GAP2_AT) v += C_GAP2;
        if (v > C_GAP3_AT) v += C_GAP3;
        if (v > C_VMAX) return 1'b0;
        jh = 8'((v / C_DIV) + int'(C_JH_BASE));
        jl = 8'((v % C_DIV) + int'(C_JL_BASE));
        word = {jh, jl};
        if (word < 16'h889F || word > 16'hEEEC) return 1'b0;
        return 1'b1;
    endfunction

    function void add_expected(input logic [7:0] c, input logic l, input logic e);
        t_code_out exp_item;
        exp_item.code = c;
        exp_item.last = l;
        exp_item.endm = e;
        code_q.insert(code_q.size(), exp_item);
    endfunction

    function void note_request(input logic [7:0] b, input logic e);
        logic [7:0] jh;
        logic [7:0] jl;
        n_in++;
        if (lead_held) begin
            if (map_pair(lead_byte, b, jh, jl)) begin
                add_expected(jh, 1'b0, e);
                add_expected(jl, 1'b1, e);
                n_mapped++;
            end else begin
                n_dropped++;
            end
            lead_held = 1'b0;
            lead_byte = '0;
        end else if (b >= C_LEAD_MIN && b <= C_LEAD_MAX) begin
            if (!e) begin
                lead_held = 1'b1;
                lead_byte = b;
            end else begin
                n_lone++;
            end
        end else begin
            add_expected(b, 1'b1, e);
            n_single++;
        end
        if (e) begin
            lead_held = 1'b0;
            lead_byte = '0;
        end
    endfunction

    function void check_result(input logic [7:0] b, input logic last, input logic endm);
        t_code_out exp_code;
        n_out++;
        if (code_q.size() == 0) begin
            $error("unexpected request: out_byte %h run_last %b end_mark %b", b, last, endm);
            n_errors++;
            return;
        end
        exp_code = code_q.pop_front();
        if (b !== exp_code.code) begin
            $error("out_byte: expected %h, got %h", exp_code.code, b);
            n_errors++;
        end
        if (last !== exp_code.last) begin
            $error("run_last: expected %b, got %b", exp_code.last, last);
            n_errors++;
        end
        if (endm !== exp_code.endm) begin
            $error("end_mark: expected %b, got %b", exp_code.endm, endm);
            n_errors++;
        end
    endfunction
endclass

module tb_top;
    localparam int N_ITEMS   = 1400;
    localparam int N_CALM    = 150;
    localparam int IDLE_LIMIT = 500;

    bit   i_clk;
    logic i_rst_n;
    bit   calm;
    int   n_sent;
    int   stall_left;
    int   idle_cycles;

    euks_in_if  in_bus();
    euks_out_if out_bus();

    remap_scoreboard remap_sb = new();

    euckr_to_sjis_code_remap dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        i_rst_n          = 1'b0;
        in_bus.valid     = 1'b0;
        in_bus.in_byte   = '0;
        in_bus.text_end  = 1'b0;
        out_bus.ready    = 1'b0;
    end

    always @(negedge i_clk) begin
        if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 5);
        if (stall_left > 0) begin
            out_bus.ready <= 1'b0;
            stall_left--;
        end else begin
            out_bus.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_bus.valid && in_bus.ready)
            remap_sb.note_request(in_bus.in_byte, in_bus.text_end);
        if (i_rst_n && out_bus.valid && out_bus.ready)
            remap_sb.check_result(out_bus.out_byte, out_bus.run_last, out_bus.end_mark);
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic e);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            in_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_bus.valid    <= 1'b1;
        in_bus.in_byte  <= b;
        in_bus.text_end <= e;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
        n_sent++;
    endtask

    task automatic send_pair(input logic [7:0] hi, input logic [7:0] lo, input logic e);
        send_byte(hi, 1'b0);
        send_byte(lo, e);
    endtask

    initial begin
        int         pick;
        logic       e;
        logic [7:0] hi;
        logic [7:0] lo;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // single bytes at the edges of the pass-through range
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b1);
        // lowest mapped pair, highest mapped pair, the first pair past the range and the last pair
        send_pair(8'hA0, 8'hA0, 1'b0);
        send_pair(8'hCA, 8'hBD, 1'b0);
        send_pair(8'hCA, 8'hBE, 1'b0);
        send_pair(8'hFE, 8'hFF, 1'b0);
        // substituted pairs
        send_pair(C_EX0_HI, C_EX0_LO, 1'b0);
        send_pair(C_EX1_HI, C_EX1_LO, 1'b0);
        send_pair(C_EX2_HI, C_EX2_LO, 1'b0);
        // pairs with a byte below the mapped range, and a lead byte as trail
        send_pair(8'h81, 8'h41, 1'b0);
        send_pair(8'hA0, 8'h9F, 1'b0);
        send_pair(8'hB0, 8'h81, 1'b0);
        // text end on a trail byte, a lone lead byte at text end, then a single byte at text end
        send_pair(8'hB0, 8'hA1, 1'b1);
        send_byte(8'hB0, 1'b1);
        send_byte(8'h41, 1'b1);

        while (n_sent < N_ITEMS) begin
            calm = (n_sent >= N_ITEMS - N_CALM);
            pick = $urandom_range(0, 99);
            e    = ($urandom_range(0, 19) == 0);
            if (pick < 30) begin
                lo = ($urandom_range(0, 15) == 0) ? 8'hFF : 8'($urandom_range(0, 8'h80));
                send_byte(lo, e);
            end else if (pick < 75) begin
                hi = 8'($urandom_range(8'hA0, 8'hCB));
                lo = 8'($urandom_range(8'hA0, 8'hFF));
                send_pair(hi, lo, e);
            end else if (pick < 80) begin
                case ($urandom_range(0, 2))
                    0: send_pair(C_EX0_HI, C_EX0_LO, e);
                    1: send_pair(C_EX1_HI, C_EX1_LO, e);
                    default: send_pair(C_EX2_HI, C_EX2_LO, e);
                endcase
            end else if (pick < 88) begin
                hi = 8'($urandom_range(8'h81, 8'hFE));
                lo = 8'($urandom_range(0, 255));
                send_pair(hi, lo, e);
            end else begin
                send_byte(8'($urandom_range(0, 255)), e);
            end
        end
        in_bus.valid <= 1'b0;

        while (remap_sb.code_q.size() > 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        remap_sb.n_errors += remap_sb.code_q.size();

        $display("summary: %0d bytes in, %0d bytes out, %0d single bytes passed",
                 remap_sb.n_in, remap_sb.n_out, remap_sb.n_single);
        $display("summary: %0d pairs mapped, %0d pairs dropped, %0d lone leads at text end",
                 remap_sb.n_mapped, remap_sb.n_dropped, remap_sb.n_lone);
        if (remap_sb.n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
